// ===== rtl/core/estm_pkg.sv =====
package estm_pkg;

    // Field and register widths
    localparam int MIX_W    = 16;
    localparam int GAIN_W   = 24;
    localparam int RAMP_W   = 16;
    localparam int NOTE_W   = 24;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int SINE_W   = 15;

    // Register reset values
    localparam logic [GAIN_W-1:0] GAIN_STEP_RST   = 24'd8389;
    localparam logic [RAMP_W-1:0] RAMP_LENGTH_RST = 16'd1000;
    localparam logic [NOTE_W-1:0] NOTE_LENGTH_RST = 24'd44100;

    // Register indexes on the config port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PHASE_STEP  = 2'd0,
        CFG_GAIN_STEP   = 2'd1,
        CFG_RAMP_LENGTH = 2'd2,
        CFG_NOTE_LENGTH = 2'd3
    } t_cfg_idx;

    // Microprogram step addresses
    typedef logic [2:0] t_pc;
    localparam t_pc STEP_WAIT    = 3'd0;
    localparam t_pc STEP_RESTART = 3'd1;
    localparam t_pc STEP_EVAL    = 3'd2;
    localparam t_pc STEP_MUL1    = 3'd3;
    localparam t_pc STEP_MUL2    = 3'd4;
    localparam t_pc STEP_ROUND   = 3'd5;
    localparam t_pc STEP_COMMIT  = 3'd6;
    localparam t_pc STEP_PASS    = 3'd7;

    // Sequencer branch conditions
    typedef enum logic [1:0] {
        COND_NEXT,
        COND_WAIT_IN,
        COND_SKIP_IDLE,
        COND_JUMP
    } t_cond;

    // Datapath control, one bit per operation
    typedef struct packed {
        logic accept;
        logic restart;
        logic eval;
        logic mul1;
        logic mul2;
        logic rnd;
        logic commit;
        logic pass;
    } t_ctl;

    // Datapath status back to the sequencer
    typedef struct packed {
        logic in_xfer;
        logic note_idle;
        logic out_free;
    } t_stat;

    typedef struct packed {
        t_ctl  ctl;
        t_cond cond;
        t_pc   target;
    } t_uword;

    // Control store
    function automatic t_uword f_ucode(t_pc pc);
        t_uword w;
        w = '0;
        unique case (pc)
            STEP_WAIT: begin
                w.ctl.accept = 1'b1;
                w.cond       = COND_WAIT_IN;
            end
            STEP_RESTART: begin
                w.ctl.restart = 1'b1;
                w.cond        = COND_NEXT;
            end
            STEP_EVAL: begin
                w.ctl.eval = 1'b1;
                w.cond     = COND_SKIP_IDLE;
                w.target   = STEP_PASS;
            end
            STEP_MUL1: begin
                w.ctl.mul1 = 1'b1;
                w.cond     = COND_NEXT;
            end
            STEP_MUL2: begin
                w.ctl.mul2 = 1'b1;
                w.cond     = COND_NEXT;
            end
            STEP_ROUND: begin
                w.ctl.rnd = 1'b1;
                w.cond    = COND_NEXT;
            end
            STEP_COMMIT: begin
                w.ctl.commit = 1'b1;
                w.cond       = COND_JUMP;
                w.target     = STEP_WAIT;
            end
            STEP_PASS: begin
                w.ctl.pass = 1'b1;
                w.cond     = COND_JUMP;
                w.target   = STEP_WAIT;
            end
            default: begin
                w = '0;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/estm_if.sv =====
// Input channel
interface estm_in_if;
    import estm_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [MIX_W-1:0] mix_in;
    logic                    note_start;
    modport source (output valid, output mix_in, output note_start, input ready);
    modport sink   (input valid, input mix_in, input note_start, output ready);
endinterface

// Output channel
interface estm_out_if;
    import estm_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [MIX_W-1:0] mix_out;
    logic                    note_end;
    modport source (output valid, output mix_out, output note_end, input ready);
    modport sink   (input valid, input mix_out, input note_end, output ready);
endinterface

// ===== rtl/core/estm_sine_rom.sv =====
module estm_sine_rom #(
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                         i_clk,
    input  logic [AW-1:0]                i_addr,
    output logic [estm_pkg::SINE_W-1:0]  o_data
);
    import estm_pkg::*;

    typedef logic [SINE_W-1:0] t_rom_arr [DEPTH];

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] TWO_DEPTH   = 64'(2 * DEPTH);
    localparam logic [63:0] DIV0 = 64'd110;
    localparam logic [63:0] DIV1 = 64'd72;
    localparam logic [63:0] DIV2 = 64'd42;
    localparam logic [63:0] DIV3 = 64'd20;
    localparam logic [63:0] DIV4 = 64'd6;

    // Quarter-wave table, Q30 Taylor series to the x^11 term at mid-bin points
    function automatic t_rom_arr f_fill();
        t_rom_arr    arr;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] q;
        for (int k = 0; k < DEPTH; k++) begin
            x  = ((64'(2 * k + 1)) * HALF_PI_Q30) / TWO_DEPTH;
            x2 = (x * x) >> 30;
            t  = Q30_ONE;
            t  = Q30_ONE - (((x2 * t) >> 30) / DIV0);
            t  = Q30_ONE - (((x2 * t) >> 30) / DIV1);
            t  = Q30_ONE - (((x2 * t) >> 30) / DIV2);
            t  = Q30_ONE - (((x2 * t) >> 30) / DIV3);
            t  = Q30_ONE - (((x2 * t) >> 30) / DIV4);
            s  = (x * t) >> 30;
            q  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
            arr[k] = q[SINE_W-1:0];
        end
        return arr;
    endfunction

    localparam t_rom_arr SINE_ROM = f_fill();

    // Registered read
    always_ff @(posedge i_clk) begin
        o_data <= SINE_ROM[i_addr];
    end

endmodule

// ===== rtl/core/estm_seq.sv =====
module estm_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  estm_pkg::t_stat i_stat,
    output estm_pkg::t_ctl  o_ctl
);
    import estm_pkg::*;

    t_pc    r_pc;
    t_pc    n_pc;
    t_uword w_word;
    logic   w_hold;

    // Fetch and branch
    always_comb begin
        w_word = f_ucode(r_pc);
        w_hold = (w_word.ctl.commit || w_word.ctl.pass) && !i_stat.out_free;
        unique case (w_word.cond)
            COND_NEXT:      n_pc = r_pc + 3'd1;
            COND_WAIT_IN:   n_pc = i_stat.in_xfer ? r_pc + 3'd1 : r_pc;
            COND_SKIP_IDLE: n_pc = i_stat.note_idle ? w_word.target : r_pc + 3'd1;
            COND_JUMP:      n_pc = w_hold ? r_pc : w_word.target;
            default:        n_pc = STEP_WAIT;
        endcase
    end

    // Control word out; result writes wait for a free output register
    always_comb begin
        o_ctl        = w_word.ctl;
        o_ctl.commit = w_word.ctl.commit && !w_hold;
        o_ctl.pass   = w_word.ctl.pass && !w_hold;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= STEP_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

// ===== rtl/core/estm_dp.sv =====
module estm_dp #(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int PHASE_BITS       = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [estm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [estm_pkg::CFG_W-1:0]      i_cfg_data,
    input  estm_pkg::t_ctl                  i_ctl,
    output estm_pkg::t_stat                 o_stat,
    estm_in_if.sink                         i_in,
    estm_out_if.source                      o_out
);
    import estm_pkg::*;

    localparam int AW = $clog2(SINE_TABLE_DEPTH);
    localparam int DW = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int MW = 30 + DW;
    localparam logic [DW-1:0] DEPTH_C = DW'(SINE_TABLE_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(SINE_TABLE_DEPTH - 1);
    localparam int P1_W = RAMP_W + GAIN_W;
    localparam int P2_W = P1_W + SINE_W;
    localparam logic [P2_W:0] ROUND_HALF = (P2_W + 1)'(1) << 23;
    localparam int TERM_W = P2_W + 1 - 24;
    localparam int SUM_W = TERM_W + 2;
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(32768);

    // Configuration
    logic [PHASE_BITS-1:0] r_phase_step;
    logic [GAIN_W-1:0]     r_gain_step;
    logic [RAMP_W-1:0]     r_ramp_length;
    logic [NOTE_W-1:0]     r_note_length;

    // Note state
    logic [PHASE_BITS-1:0] r_phase_acc;
    logic [NOTE_W-1:0]     r_sample_index;
    logic [RAMP_W-1:0]     r_ramp_count;

    // Item working registers
    logic signed [MIX_W-1:0] r_mix;
    logic                    r_start;
    logic                    r_rise;
    logic                    r_fall;
    logic                    r_end;
    logic                    r_neg;
    logic [AW-1:0]           r_rom_addr;
    logic [P1_W-1:0]         r_p1;
    logic [P2_W-1:0]         r_p2;
    logic [TERM_W-1:0]       r_term;

    // Output register
    logic                    r_out_valid;
    logic signed [MIX_W-1:0] r_mix_out;
    logic                    r_note_end;

    logic [SINE_W-1:0]        w_sine;
    logic [31:0]              w_ph32;
    logic [MW-1:0]            w_pos_prod;
    logic [AW-1:0]            w_pos;
    logic [NOTE_W:0]          w_idx_inc;
    logic [NOTE_W:0]          w_idx_ramp;
    logic [P2_W:0]            w_rnd;
    logic signed [SUM_W-1:0]  w_mix_ext;
    logic signed [SUM_W-1:0]  w_term_ext;
    logic signed [SUM_W-1:0]  w_sum;
    logic signed [MIX_W-1:0]  w_sat;

    estm_sine_rom #(
        .DEPTH (SINE_TABLE_DEPTH),
        .AW    (AW)
    ) u_rom (
        .i_clk  (i_clk),
        .i_addr (r_rom_addr),
        .o_data (w_sine)
    );

    // Handshake and status
    assign i_in.ready       = i_ctl.accept;
    assign o_stat.in_xfer   = i_in.valid && i_ctl.accept;
    assign o_stat.note_idle = r_sample_index >= r_note_length;
    assign o_stat.out_free  = !r_out_valid || o_out.ready;

    assign o_out.valid    = r_out_valid;
    assign o_out.mix_out  = r_mix_out;
    assign o_out.note_end = r_note_end;

    // Table address from the phase, mirrored in odd quadrants
    always_comb begin
        w_ph32     = 32'(r_phase_acc) << (32 - PHASE_BITS);
        w_pos_prod = MW'(w_ph32[29:0]) * MW'(DEPTH_C);
        w_pos      = w_pos_prod[30 +: AW];
        w_idx_inc  = {1'b0, r_sample_index} + (NOTE_W + 1)'(1);
        w_idx_ramp = {1'b0, r_sample_index} + (NOTE_W + 1)'(r_ramp_length);
    end

    // Rounding and saturating add
    always_comb begin
        w_rnd      = {1'b0, r_p2} + ROUND_HALF;
        w_mix_ext  = SUM_W'(r_mix);
        w_term_ext = $signed({2'b00, r_term});
        w_sum      = r_neg ? (w_mix_ext - w_term_ext) : (w_mix_ext + w_term_ext);
        priority if (w_sum > SAT_HI) begin
            w_sat = 16'sd32767;
        end else if (w_sum < SAT_LO) begin
            w_sat = -16'sd32768;
        end else begin
            w_sat = w_sum[MIX_W-1:0];
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step  <= '0;
            r_gain_step   <= GAIN_STEP_RST;
            r_ramp_length <= RAMP_LENGTH_RST;
            r_note_length <= NOTE_LENGTH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PHASE_STEP:  r_phase_step  <= i_cfg_data[CFG_W-1 -: PHASE_BITS];
                CFG_GAIN_STEP:   r_gain_step   <= i_cfg_data[GAIN_W-1:0];
                CFG_RAMP_LENGTH: r_ramp_length <= i_cfg_data[RAMP_W-1:0];
                CFG_NOTE_LENGTH: r_note_length <= i_cfg_data[NOTE_W-1:0];
                default: ;
            endcase
        end
    end

    // Phase, index and envelope
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_acc    <= '0;
            r_sample_index <= '0;
            r_ramp_count   <= '0;
        end else if (i_ctl.restart && r_start) begin
            r_phase_acc    <= '0;
            r_sample_index <= '0;
            r_ramp_count   <= '0;
        end else if (i_ctl.commit) begin
            r_phase_acc    <= r_phase_acc + r_phase_step;
            r_sample_index <= w_idx_inc[NOTE_W-1:0];
            priority if (r_rise && !r_fall) begin
                r_ramp_count <= r_ramp_count + RAMP_W'(1);
            end else if (r_fall && !r_rise && (r_ramp_count != '0)) begin
                r_ramp_count <= r_ramp_count - RAMP_W'(1);
            end else begin
                r_ramp_count <= r_ramp_count;
            end
        end
    end

    // Per-item working registers
    always_ff @(posedge i_clk) begin
        if (o_stat.in_xfer) begin
            r_mix   <= i_in.mix_in;
            r_start <= i_in.note_start;
        end
        if (i_ctl.eval) begin
            r_rise     <= w_idx_inc < (NOTE_W + 1)'(r_ramp_length);
            r_fall     <= w_idx_ramp >= (NOTE_W + 1)'(r_note_length);
            r_end      <= w_idx_inc == (NOTE_W + 1)'(r_note_length);
            r_neg      <= w_ph32[31];
            r_rom_addr <= w_ph32[30] ? (LAST_IDX - w_pos) : w_pos;
        end
        if (i_ctl.mul1) begin
            r_p1 <= P1_W'(r_ramp_count) * P1_W'(r_gain_step);
        end
        if (i_ctl.mul2) begin
            r_p2 <= P2_W'(r_p1) * P2_W'(w_sine);
        end
        if (i_ctl.rnd) begin
            r_term <= w_rnd[P2_W:24];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.commit || i_ctl.pass) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.commit) begin
            r_mix_out  <= w_sat;
            r_note_end <= r_end;
        end else if (i_ctl.pass) begin
            r_mix_out  <= r_mix;
            r_note_end <= 1'b0;
        end
    end

endmodule

// ===== rtl/core/enveloped_sine_tone_mixer_top.sv =====
// A sample inside its note passes the restart, evaluate, two multiply, round and commit
// steps after its input transfer; a sample past the note end passes restart, evaluate
// and pass. A new sample is taken only after the last one has been written to the
// output register; a stalled output holds the final step.
// Reset (i_rst_n low, synchronous) clears phase, index and envelope, loads the
// register defaults and empties the output register.
module enveloped_sine_tone_mixer_top #(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int PHASE_BITS       = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [estm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [estm_pkg::CFG_W-1:0]      i_cfg_data,
    estm_in_if.sink                         i_in,
    estm_out_if.source                      o_out
);
    import estm_pkg::*;

    t_ctl  w_ctl;
    t_stat w_stat;

    // Control sequencer
    estm_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ctl   (w_ctl)
    );

    // Datapath with sine table
    estm_dp #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .PHASE_BITS       (PHASE_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_ctl      (w_ctl),
        .o_stat     (w_stat),
        .i_in       (i_in),
        .o_out      (o_out)
    );

endmodule

// ===== rtl/core/estm_checker.sv =====
module estm_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [estm_pkg::MIX_W-1:0]  i_mix_out,
    input logic                        i_note_end
);
    import estm_pkg::*;

    // Reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // One sample at a time: no new transfer right after one
    a_in_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready right after a transfer");

    // A result does not show too early after its input transfer
    a_min_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !$rose(i_out_valid) ##1 !$rose(i_out_valid))
        else $error("result too early after input transfer");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_mix_out) && $stable(i_note_end)))
        else $error("stalled result changed");

endmodule

bind enveloped_sine_tone_mixer_top estm_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_mix_out   (o_out.mix_out),
    .i_note_end  (o_out.note_end)
);
